@@ rtl/line_rasterizer_macros.svh @@
// ----------------------------------------------------------------------------
// line_rasterizer_macros: assertion helpers for the line rasterizer
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define LR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define LR_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define LR_ASSERT(lbl, clk, rstn, prop, msg)
`define LR_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned COORD_W         = 6;
  localparam int unsigned CANVAS_SIZE_DEF = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned ERR_W           = COORD_W + 3;

  typedef logic [COORD_W-1:0] coord_t;

  // classified line, handed from the setup side to the stepper
  typedef struct packed {
    coord_t origin_col;
    coord_t origin_row;
    coord_t major_len;
    coord_t minor_len;
    logic   axes_swapped;
    logic   col_negative;
    logic   row_negative;
  } line_desc_t;

endpackage

@@ rtl/lr_setup.sv @@
// ----------------------------------------------------------------------------
// lr_setup: endpoint clamping and line classification
// Clamps the endpoints to the canvas, takes absolute deltas, direction
// signs and the major axis, and forms one line descriptor.
// ----------------------------------------------------------------------------
module lr_setup
  import lr_pkg::*;
#(
  parameter int unsigned CANVAS_SIZE = CANVAS_SIZE_DEF
) (
  input  coord_t     x_start_i,
  input  coord_t     y_start_i,
  input  coord_t     x_end_i,
  input  coord_t     y_end_i,
  output line_desc_t desc_o
);

  localparam coord_t CoordMax = COORD_W'(CANVAS_SIZE - 1);

  coord_t x0, y0, x1, y1;
  coord_t dx, dy;
  logic   col_neg, row_neg, swapped;

  always_comb begin
    x0 = (x_start_i > CoordMax) ? CoordMax : x_start_i;
    y0 = (y_start_i > CoordMax) ? CoordMax : y_start_i;
    x1 = (x_end_i   > CoordMax) ? CoordMax : x_end_i;
    y1 = (y_end_i   > CoordMax) ? CoordMax : y_end_i;

    col_neg = x1 < x0;
    row_neg = y1 < y0;
    dx      = col_neg ? (x0 - x1) : (x1 - x0);
    dy      = row_neg ? (y0 - y1) : (y1 - y0);
    // equal deltas make y the major axis
    swapped = dx <= dy;

    desc_o.origin_col   = x0;
    desc_o.origin_row   = y0;
    desc_o.major_len    = swapped ? dy : dx;
    desc_o.minor_len    = swapped ? dx : dy;
    desc_o.axes_swapped = swapped;
    desc_o.col_negative = col_neg;
    desc_o.row_negative = row_neg;
  end

endmodule

@@ rtl/lr_queue.sv @@
// ----------------------------------------------------------------------------
// lr_queue: short line descriptor queue
// Decouples the setup side from the pixel stepper.
// ----------------------------------------------------------------------------
module lr_queue
  import lr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  line_desc_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output line_desc_t pop_data_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  line_desc_t          mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o     = count_q == CntW'(QUEUE_DEPTH);
  assign valid_o    = count_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/lr_stepper.sv @@
// ----------------------------------------------------------------------------
// lr_stepper: Bresenham pixel stepper
// Takes one line descriptor at a time and, while the output is not
// stalled, emits one pixel per cycle into a registered output stage.
// ----------------------------------------------------------------------------
module lr_stepper
  import lr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       desc_valid_i,
  input  line_desc_t desc_i,
  output logic       desc_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output coord_t     pixel_x_o,
  output coord_t     pixel_y_o,
  output logic       last_pixel_o
);

`include "line_rasterizer_macros.svh"

  logic                    busy_q, busy_d;
  line_desc_t              line_q, line_d;
  coord_t                  col_q, col_d;
  coord_t                  row_q, row_d;
  coord_t                  major_step_q, major_step_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic                    out_valid_q, out_valid_d;
  coord_t                  out_x_q, out_y_q;
  logic                    out_last_q;

  logic                    out_load;
  logic                    last;
  logic                    minor_move;
  logic                    col_move, row_move;
  logic signed [ERR_W-1:0] err_sum;

  assign desc_pop_o   = !busy_q && desc_valid_i;
  assign out_load     = busy_q && (!out_valid_q || !out_stall_i);
  assign last         = major_step_q >= line_q.major_len;
  assign err_sum      = err_q + $signed({2'b00, line_q.minor_len, 1'b0});
  assign minor_move   = !err_sum[ERR_W-1];
  assign col_move     = line_q.axes_swapped ? minor_move : !last;
  assign row_move     = line_q.axes_swapped ? !last : minor_move;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = out_x_q;
  assign pixel_y_o    = out_y_q;
  assign last_pixel_o = out_last_q;

  always_comb begin
    busy_d       = busy_q;
    line_d       = line_q;
    col_d        = col_q;
    row_d        = row_q;
    major_step_d = major_step_q;
    err_d        = err_q;
    out_valid_d  = out_valid_q && out_stall_i;

    if (desc_pop_o) begin
      busy_d       = 1'b1;
      line_d       = desc_i;
      col_d        = desc_i.origin_col;
      row_d        = desc_i.origin_row;
      major_step_d = '0;
      err_d        = -$signed({3'b000, desc_i.major_len});
    end else if (out_load) begin
      out_valid_d = 1'b1;
      err_d = minor_move ? (err_sum - $signed({2'b00, line_q.major_len, 1'b0})) : err_sum;
      if (col_move) begin
        col_d = line_q.col_negative ? (col_q - 1'b1) : (col_q + 1'b1);
      end
      if (row_move) begin
        row_d = line_q.row_negative ? (row_q - 1'b1) : (row_q + 1'b1);
      end
      if (last) begin
        busy_d = 1'b0;
      end else begin
        major_step_d = major_step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q       <= line_d;
    col_q        <= col_d;
    row_q        <= row_d;
    major_step_q <= major_step_d;
    err_q        <= err_d;
    if (out_load) begin
      out_x_q    <= col_q;
      out_y_q    <= row_q;
      out_last_q <= last;
    end
  end

  // the error term never goes positive while a line runs
  `LR_ASSERT(a_err_nonpos, clk_i, rst_ni, busy_q |-> (err_q <= 0), "error term positive")
  // the major axis is never the shorter one
  `LR_ASSERT(a_major_long, clk_i, rst_ni, busy_q |-> (line_q.major_len >= line_q.minor_len), "major shorter than minor")
  // the step counter never runs past the line
  `LR_ASSERT(a_step_bound, clk_i, rst_ni, busy_q |-> (major_step_q <= line_q.major_len), "major step overrun")
  // the run ends exactly after the final pixel is loaded
  `LR_ASSERT(a_run_ends, clk_i, rst_ni, (out_load && last) |=> (!busy_q && out_last_q), "run did not end on last pixel")
  // a new line is only taken while idle
  `LR_ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, desc_pop_o && busy_q, "descriptor taken during a run")

endmodule

@@ rtl/line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line rasterizer on a square canvas
// Input channel (in_valid_i / in_stall_o) takes one line per transaction as
// two endpoints; coordinates beyond the canvas saturate to its last column
// or row. Output channel (out_valid_o / out_stall_i) gives one pixel per
// transaction, in order from the first endpoint, with last_pixel_o set on
// the final pixel. A line of major delta m gives m+1 pixels.
// The setup side classifies a line in the cycle it is accepted and pushes
// it into a two-entry queue; the input stalls only while the queue is full.
// When the block is empty, the first pixel of a line passes the queue,
// the stepper's line load and the registered output stage. The stepper
// produces one pixel per cycle while the output is not stalled, loads each
// line before its first pixel and takes no new line during a run.
// A stall on the output holds the registered pixel and halts pixel stepping;
// the queue keeps accepting lines until full.
// Reset empties the queue, ends any run and drops a pending pixel.
// ----------------------------------------------------------------------------
module line_rasterizer
  import lr_pkg::*;
#(
  parameter int unsigned CANVAS_SIZE = CANVAS_SIZE_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  coord_t x_start_i,
  input  coord_t y_start_i,
  input  coord_t x_end_i,
  input  coord_t y_end_i,
  output logic   out_valid_o,
  input  logic   out_stall_i,
  output coord_t pixel_x_o,
  output coord_t pixel_y_o,
  output logic   last_pixel_o
);

  line_desc_t setup_desc;
  line_desc_t queue_desc;
  logic       queue_full;
  logic       queue_valid;
  logic       queue_pop;
  logic       push;

  assign in_stall_o = queue_full;
  assign push       = in_valid_i && !queue_full;

  lr_setup #(
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_setup (
    .x_start_i (x_start_i),
    .y_start_i (y_start_i),
    .x_end_i   (x_end_i),
    .y_end_i   (y_end_i),
    .desc_o    (setup_desc)
  );

  lr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (setup_desc),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_desc)
  );

  lr_stepper u_stepper (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (queue_valid),
    .desc_i       (queue_desc),
    .desc_pop_o   (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

endmodule
